/* sv/crcf_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the packet framer.
package crcf_pkg;

    localparam int FRAME_BYTES = 128;
    localparam logic [7:0] LAST_POS = 8'(FRAME_BYTES - 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // Byte order within a start run
    localparam logic [2:0] STEP_PRE_HI = 3'd0;
    localparam logic [2:0] STEP_PRE_LO = 3'd1;
    localparam logic [2:0] STEP_SIZE   = 3'd2;
    localparam logic [2:0] STEP_HDR    = 3'd3;
    localparam logic [2:0] STEP_LEN    = 3'd4;
    localparam logic [2:0] STEP_CRC    = 3'd5;

    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_FLUSH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] byte_a;   // size on start, payload byte on data
        logic [7:0] hdr;
        logic [7:0] len;
        logic [7:0] crc;
        logic [2:0] last_idx;
    } cmd_t;

    localparam logic [7:0] CRC_TERMS [8] = '{
        8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
    };

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] x;
        logic [7:0] r;
        x = crc ^ data;
        r = 8'h00;
        for (int b = 0; b < 8; b++)
        begin
            if (x[b])
            begin
                r = r ^ CRC_TERMS[b];
            end
        end
        return r;
    endfunction

endpackage

/* sv/crcf_if.sv */
// Stream interfaces for the framer input items and the buffer write beats.
interface crcf_rx_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] header_byte;
    logic [7:0] payload_length;
    logic [7:0] data_byte;

    modport source (output valid, kind, header_byte, payload_length, data_byte, input ready);
    modport sink (input valid, kind, header_byte, payload_length, data_byte, output ready);
endinterface

interface crcf_tx_if;
    logic       valid;
    logic       ready;
    logic       buffer_select;
    logic [6:0] write_address;
    logic [7:0] write_data;
    logic       frame_ready;
    logic       last_of_run;

    modport source (output valid, buffer_select, write_address, write_data, frame_ready,
                    last_of_run, input ready);
    modport sink (input valid, buffer_select, write_address, write_data, frame_ready,
                  last_of_run, output ready);
endinterface

/* sv/crcf_front.sv */
// Front end: accepts input items, tracks packet state and the CRC, queues commands.
module crcf_front (
    input  logic          clk,
    input  logic          rst_n,
    crcf_rx_if.sink       rx,
    input  logic          q_full,
    output logic          push,
    output crcf_pkg::cmd_t push_cmd
);
    import crcf_pkg::*;

    logic       in_packet_reg, in_packet_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] crc_reg, crc_next;
    logic       accept;
    logic [7:0] size;
    logic [7:0] crc_hdr;
    logic [7:0] crc_dat;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && !q_full;
    assign size     = rx.payload_length + 8'd2;
    assign crc_hdr  = crc_update(crc_update(crc_update(8'h00, size), rx.header_byte),
                                 rx.payload_length);
    assign crc_dat  = crc_update(crc_reg, rx.data_byte);

    always_comb
    begin
        push            = 1'b0;
        push_cmd.op     = OP_FLUSH;
        push_cmd.byte_a = size;
        push_cmd.hdr    = rx.header_byte;
        push_cmd.len    = rx.payload_length;
        push_cmd.crc    = crc_hdr;
        push_cmd.last_idx = STEP_LEN;
        in_packet_next  = in_packet_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        if (accept)
        begin
            unique case (rx.kind)
                KIND_START:
                begin
                    // an open packet is dropped without its CRC
                    push            = 1'b1;
                    push_cmd.op     = OP_START;
                    push_cmd.last_idx = (rx.payload_length == 8'd0) ? STEP_CRC : STEP_LEN;
                    in_packet_next  = (rx.payload_length != 8'd0);
                    bytes_left_next = rx.payload_length;
                    crc_next        = crc_hdr;
                end
                KIND_DATA:
                begin
                    if (in_packet_reg)
                    begin
                        push            = 1'b1;
                        push_cmd.op     = OP_DATA;
                        push_cmd.byte_a = rx.data_byte;
                        push_cmd.crc    = crc_dat;
                        push_cmd.last_idx = (bytes_left_reg == 8'd1) ? 3'd1 : 3'd0;
                        bytes_left_next = bytes_left_reg - 8'd1;
                        crc_next        = crc_dat;
                        if (bytes_left_reg == 8'd1)
                        begin
                            in_packet_next = 1'b0;
                        end
                    end
                end
                KIND_FLUSH:
                begin
                    push        = 1'b1;
                    push_cmd.op = OP_FLUSH;
                end
                default:
                begin
                    // unused kind: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            bytes_left_reg <= 8'd0;
            crc_reg        <= 8'd0;
        end
        else
        begin
            in_packet_reg  <= in_packet_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

/* sv/crcf_queue.sv */
// Short command queue between the front end and the write sequencer.
module crcf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  crcf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output crcf_pkg::cmd_t head_cmd
);
    import crcf_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

/* sv/crcf_back.sv */
// Back end: runs queued commands as buffer write beats, handles release and buffer swap.
module crcf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           preamble_we,
    input  logic [15:0]    preamble_wdata,
    input  logic           head_valid,
    input  crcf_pkg::cmd_t head_cmd,
    output logic           pop,
    crcf_tx_if.source      tx
);
    import crcf_pkg::*;

    logic [15:0] preamble_reg;
    logic        active_reg, active_next;
    logic [7:0]  wp_reg, wp_next;
    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic        sel_reg;
    logic [6:0]  addr_reg;
    logic [7:0]  data_reg;
    logic        rdy_reg;
    logic        last_reg;
    logic        go;
    logic        emit;
    logic        emit_release;
    logic        emit_last;
    logic [7:0]  cur_byte;
    logic [7:0]  wp_inc;

    assign go     = head_valid && (!out_valid_reg || tx.ready);
    assign wp_inc = wp_reg + 8'd1;

    always_comb
    begin
        cur_byte = head_cmd.crc;
        if (head_cmd.op == OP_DATA)
        begin
            cur_byte = (step_reg == 3'd0) ? head_cmd.byte_a : head_cmd.crc;
        end
        else
        begin
            unique case (step_reg)
                STEP_PRE_HI: cur_byte = preamble_reg[15:8];
                STEP_PRE_LO: cur_byte = preamble_reg[7:0];
                STEP_SIZE:   cur_byte = head_cmd.byte_a;
                STEP_HDR:    cur_byte = head_cmd.hdr;
                STEP_LEN:    cur_byte = head_cmd.len;
                default:     cur_byte = head_cmd.crc;
            endcase
        end
    end

    always_comb
    begin
        pop          = 1'b0;
        emit         = 1'b0;
        emit_release = 1'b0;
        emit_last    = 1'b0;
        active_next  = active_reg;
        wp_next      = wp_reg;
        step_next    = step_reg;
        if (go)
        begin
            if (head_cmd.op == OP_FLUSH)
            begin
                pop = 1'b1;
                if (wp_reg != 8'd0)
                begin
                    emit         = 1'b1;
                    emit_release = 1'b1;
                    emit_last    = 1'b1;
                    active_next  = !active_reg;
                    wp_next      = 8'd0;
                end
            end
            else if (wp_reg == LAST_POS)
            begin
                // buffer full: release before the pending byte, hold the step
                emit         = 1'b1;
                emit_release = 1'b1;
                active_next  = !active_reg;
                wp_next      = 8'd0;
            end
            else
            begin
                emit      = 1'b1;
                emit_last = (step_reg == head_cmd.last_idx);
                wp_next   = wp_inc;
                pop       = emit_last;
                step_next = emit_last ? 3'd0 : step_reg + 3'd1;
            end
        end
        out_valid_next = emit || (out_valid_reg && !tx.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg  <= 16'd0;
            active_reg    <= 1'b0;
            wp_reg        <= 8'd0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (preamble_we)
            begin
                preamble_reg <= preamble_wdata;
            end
            active_reg    <= active_next;
            wp_reg        <= wp_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sel_reg  <= active_reg;
            addr_reg <= emit_release ? 7'd0 : wp_inc[6:0];
            data_reg <= emit_release ? wp_reg : cur_byte;
            rdy_reg  <= emit_release;
            last_reg <= emit_last;
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.buffer_select = sel_reg;
    assign tx.write_address = addr_reg;
    assign tx.write_data    = data_reg;
    assign tx.frame_ready   = rdy_reg;
    assign tx.last_of_run   = last_reg;

    a_release_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rdy_reg |-> addr_reg == 7'd0)
        else $error("release beat not at address zero");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_POS)
        else $error("write position past end of buffer");

endmodule

/* sv/crc8_packet_framer_double_buffer.sv */
// Top level of the CRC-8 packet framer writing into two ping-pong buffers.
//
// Channels: rx carries input items (packet start, payload byte, idle flush);
// tx carries one buffer write per beat (buffer, address, data, frame_ready,
// last_of_run). preamble_we/preamble_wdata load the 16-bit preamble; write it
// only while the block is idle.
// Flow: with the queue empty, the first write beat of an item passes through the
// command queue and the output register before it is presented on tx. The write
// sequencer issues one beat per cycle while tx.ready stays high; a packet start
// gives 5 to 7 beats, a payload byte 1 to 3 and a flush its release beat or none;
// ignored items give none. Each item is accepted into a four-entry command queue,
// so items are accepted at one per cycle while the queue is not full, and rx
// stalls only while the queue is full.
// Reset: clears packet state, CRC, write position, selects buffer A, empties
// the queue and the output register; the preamble returns to zero.
// Stall: when tx.ready is low the current beat holds; the sequencer stops and
// the queue fills, then rx.ready drops. No beat is lost or repeated.
module crc8_packet_framer_double_buffer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        preamble_we,
    input  logic [15:0] preamble_wdata,
    crcf_rx_if.sink     rx,
    crcf_tx_if.source   tx
);
    import crcf_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    crcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    crcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    crcf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .preamble_we    (preamble_we),
        .preamble_wdata (preamble_wdata),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .tx             (tx)
    );

endmodule

/* dv/crc8_packet_framer_double_buffer_test.sv */
// Self-checking testbench for the CRC-8 packet framer with ping-pong frame buffers.
module crc8_packet_framer_double_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crcf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8c;
    localparam int PREDICTED = -1;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER_BEATS = 120;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic       buffer_select;
        logic [6:0] write_address;
        logic [7:0] write_data;
        logic       frame_ready;
        logic       last_of_run;
    } wbeat_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t   what;
        logic [1:0]  kind;
        logic [7:0]  header_byte;
        logic [7:0]  payload_length;
        logic [7:0]  data_byte;
        logic [15:0] preamble;
        int          typed_n;
        wbeat_t      typed_beat;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        preamble_we;
    logic [15:0] preamble_wdata;

    crcf_rx_if rx_ch();
    crcf_tx_if tx_ch();

    crc8_packet_framer_double_buffer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .preamble_we    (preamble_we),
        .preamble_wdata (preamble_wdata),
        .rx             (rx_ch),
        .tx             (tx_ch)
    );

    // Framer state as the block should hold it
    logic        act_buf = 1'b0;
    logic [7:0]  wr_pos = 8'd0;
    logic [7:0]  crc_acc = 8'd0;
    logic [7:0]  remaining = 8'd0;
    logic        open_pkt = 1'b0;
    logic [15:0] preamble_q = 16'd0;

    wbeat_t run_beats[$];
    wbeat_t due_beats[$];
    int     mismatches = 0;
    int     framed_items = 0;
    int     send_burst = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic wbeat_t beat_of(logic sel, logic [6:0] addr, logic [7:0] dat,
                                       logic rdy, logic last);
        wbeat_t w;
        w.buffer_select = sel;
        w.write_address = addr;
        w.write_data = dat;
        w.frame_ready = rdy;
        w.last_of_run = last;
        return w;
    endfunction

    // Reflected Dallas CRC-8, one bit at a time
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    function automatic void close_buffer();
        run_beats.push_back(beat_of(act_buf, 7'd0, wr_pos, 1'b1, 1'b0));
        act_buf = ~act_buf;
        wr_pos = 8'd0;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        if (wr_pos >= LAST_POS)
            close_buffer();
        run_beats.push_back(beat_of(act_buf, wr_pos[6:0] + 7'd1, b, 1'b0, 1'b0));
        wr_pos++;
    endfunction

    // Work out the buffer writes one input item causes, in order
    function automatic void frame_item(input logic [1:0] k, input logic [7:0] h,
                                       input logic [7:0] l, input logic [7:0] d);
        logic [7:0] size_b;
        wbeat_t     tail;
        run_beats.delete();
        case (k)
            KIND_START:
            begin
                size_b = l + 8'd2;
                crc_acc = crc8_step(crc8_step(crc8_step(8'd0, size_b), h), l);
                put_byte(preamble_q[15:8]);
                put_byte(preamble_q[7:0]);
                put_byte(size_b);
                put_byte(h);
                put_byte(l);
                if (l == 8'd0)
                begin
                    put_byte(crc_acc);
                    open_pkt = 1'b0;
                    remaining = 8'd0;
                end
                else
                begin
                    open_pkt = 1'b1;
                    remaining = l;
                end
            end
            KIND_DATA:
            begin
                if (open_pkt)
                begin
                    crc_acc = crc8_step(crc_acc, d);
                    put_byte(d);
                    remaining--;
                    if (remaining == 8'd0)
                    begin
                        put_byte(crc_acc);
                        open_pkt = 1'b0;
                    end
                end
            end
            KIND_FLUSH:
            begin
                if (wr_pos > 8'd0)
                    close_buffer();
            end
            default:
            begin
            end
        endcase
        if (run_beats.size() > 0)
        begin
            tail = run_beats.pop_back();
            tail.last_of_run = 1'b1;
            run_beats.push_back(tail);
        end
    endfunction

    function automatic stim_row_t item_row(logic [1:0] k, logic [7:0] h, logic [7:0] l,
                                           logic [7:0] d, int typed_n = PREDICTED,
                                           wbeat_t typed_beat = '0);
        stim_row_t r;
        r.what = ROW_ITEM;
        r.kind = k;
        r.header_byte = h;
        r.payload_length = l;
        r.data_byte = d;
        r.preamble = 16'd0;
        r.typed_n = typed_n;
        r.typed_beat = typed_beat;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [15:0] v);
        stim_row_t r;
        r = item_row(KIND_UNUSED, 8'd0, 8'd0, 8'd0);
        r.what = ROW_CFG;
        r.preamble = v;
        return r;
    endfunction

    task automatic offer_item(input logic [1:0] k, input logic [7:0] h, input logic [7:0] l,
                              input logic [7:0] d, input int typed_n = PREDICTED,
                              input wbeat_t typed_beat = '0);
        int gap;
        gap = draw_wait(send_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.kind <= k;
        rx_ch.header_byte <= h;
        rx_ch.payload_length <= l;
        rx_ch.data_byte <= d;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        frame_item(k, h, l, d);
        if (run_beats.size() > 0)
            framed_items++;
        if (typed_n == PREDICTED)
        begin
            foreach (run_beats[i])
                due_beats.push_back(run_beats[i]);
        end
        else if (typed_n == 1)
        begin
            due_beats.push_back(typed_beat);
        end
    endtask

    // Drop valid, let every write and any no-result item drain, then load the preamble
    task automatic load_preamble(input logic [15:0] v);
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        preamble_we <= 1'b1;
        preamble_wdata <= v;
        @(negedge clk);
        preamble_we <= 1'b0;
        preamble_q = v;
    endtask

    // Write beat sink and checker
    initial
    begin
        int     stall;
        int     beats_taken;
        int     recv_burst;
        bit     held;
        wbeat_t want;
        tx_ch.ready = 1'b0;
        beats_taken = 0;
        recv_burst = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(recv_burst);
            // One long hold-off while items keep coming, so the queue fills
            if (!held && beats_taken >= HOLD_AFTER_BEATS && rx_ch.valid)
            begin
                stall = HOLD_CYCLES;
                held = 1'b1;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            tx_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!tx_ch.valid);
            beats_taken++;
            if (due_beats.size() == 0)
            begin
                $error("write beat with nothing expected: buf %0d addr %0d data 0x%02h",
                       tx_ch.buffer_select, tx_ch.write_address, tx_ch.write_data);
                mismatches++;
            end
            else
            begin
                want = due_beats.pop_front();
                if (tx_ch.buffer_select !== want.buffer_select)
                begin
                    $error("buffer_select: expected %0d, got %0d",
                           want.buffer_select, tx_ch.buffer_select);
                    mismatches++;
                end
                if (tx_ch.write_address !== want.write_address)
                begin
                    $error("write_address: expected %0d, got %0d",
                           want.write_address, tx_ch.write_address);
                    mismatches++;
                end
                if (tx_ch.write_data !== want.write_data)
                begin
                    $error("write_data: expected 0x%02h, got 0x%02h",
                           want.write_data, tx_ch.write_data);
                    mismatches++;
                end
                if (tx_ch.frame_ready !== want.frame_ready)
                begin
                    $error("frame_ready: expected %0d, got %0d",
                           want.frame_ready, tx_ch.frame_ready);
                    mismatches++;
                end
                if (tx_ch.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, tx_ch.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("crc8_packet_framer_double_buffer_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t plan[$];
        int        phase;
        int        len;
        int        pick;
        int        n;

        rst_n = 1'b0;
        preamble_we = 1'b0;
        preamble_wdata = 16'd0;
        rx_ch.valid = 1'b0;
        rx_ch.kind = KIND_START;
        rx_ch.header_byte = 8'd0;
        rx_ch.payload_length = 8'd0;
        rx_ch.data_byte = 8'd0;

        // Payload while idle, flush with nothing pending, and the unused kind give nothing
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'hff, 0));
        plan.push_back(item_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 0));
        plan.push_back(item_row(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 0));
        // Empty packet with the reset preamble, then release its six bytes
        plan.push_back(item_row(KIND_START, 8'h00, 8'h00, 8'h00));
        plan.push_back(item_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1,
                                beat_of(1'b0, 7'd0, 8'd6, 1'b1, 1'b1)));
        plan.push_back(cfg_row(16'hffff));
        plan.push_back(item_row(KIND_START, 8'hff, 8'd3, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'hff, 8'hff, 8'hff));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'ha5));
        // Restart in the middle of a packet
        plan.push_back(item_row(KIND_START, 8'h5a, 8'd2, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'h12));
        plan.push_back(item_row(KIND_START, 8'h01, 8'd1, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'h80));
        // Longest legal packet, cut by a timeout, continued in the other buffer
        plan.push_back(item_row(KIND_START, 8'h3c, 8'd253, 8'h00));
        plan.push_back(item_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'h77));
        // Lengths past range wrap the size byte
        plan.push_back(item_row(KIND_START, 8'hc3, 8'd255, 8'h00));
        plan.push_back(item_row(KIND_START, 8'he7, 8'd254, 8'h00));
        plan.push_back(cfg_row(16'h00ff));
        plan.push_back(item_row(KIND_START, 8'haa, 8'd0, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'h55, 0));
        plan.push_back(cfg_row(16'h0000));
        plan.push_back(item_row(KIND_START, 8'h81, 8'd1, 8'h00));
        plan.push_back(item_row(KIND_DATA, 8'h00, 8'h00, 8'h7e));
        plan.push_back(item_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].what == ROW_CFG)
                load_preamble(plan[i].preamble);
            else
                offer_item(plan[i].kind, plan[i].header_byte, plan[i].payload_length,
                           plan[i].data_byte, plan[i].typed_n, plan[i].typed_beat);
        end

        // Mostly whole packets with random content; some timeouts, aborts and noise
        for (phase = 0; phase < 4; phase++)
        begin
            load_preamble(16'($urandom_range(0, 65535)));
            framed_items = 0;
            while (framed_items < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                        len = $urandom_range(0, 12);
                    else if (pick < 95)
                        len = $urandom_range(13, 60);
                    else
                        len = $urandom_range(61, 255);
                    offer_item(KIND_START, rand_byte(), 8'(len), rand_byte());
                    for (n = 0; n < len && framed_items < ITEMS_PER_PHASE; n++)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 2)
                            offer_item(KIND_FLUSH, rand_byte(), rand_byte(), rand_byte());
                        else if (pick < 4)
                            break;
                        offer_item(KIND_DATA, rand_byte(), rand_byte(), rand_byte());
                    end
                end
                else if (pick < 85)
                    offer_item(KIND_FLUSH, rand_byte(), rand_byte(), rand_byte());
                else if (pick < 93)
                    offer_item(KIND_DATA, rand_byte(), rand_byte(), rand_byte());
                else
                    offer_item(KIND_UNUSED, rand_byte(), rand_byte(), rand_byte());
            end
        end

        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("crc8_packet_framer_double_buffer_test: done, clean");
        else
            $display("crc8_packet_framer_double_buffer_test: done, errors");
        $finish;
    end

endmodule

/* files.f */
sv/crcf_pkg.sv
sv/crcf_if.sv
sv/crcf_front.sv
sv/crcf_queue.sv
sv/crcf_back.sv
sv/crc8_packet_framer_double_buffer.sv
dv/crc8_packet_framer_double_buffer_test.sv
